### hdl/mdd_pkg.sv
// Shared types, constants and helpers for the multi-instance deadlock detector.
// Used by every module of the block but mdd_ram; depends on nothing.
package mdd_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int MAX_RESOURCES = 8;

	localparam int PROC_W    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int RES_W     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int MAT_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

	localparam int AMT_W      = 8;
	localparam int AVAIL_W    = 13;
	localparam int CMD_W      = 2;
	localparam int PIDX_W     = 4;
	localparam int RIDX_W     = 3;
	localparam int CFG_RES_W  = 4;
	localparam int CFG_PROC_W = 5;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_TOTAL = 2'd0,
		CMD_LOAD_HOLD  = 2'd1,
		CMD_LOAD_REQ   = 2'd2,
		CMD_RUN        = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_RESOURCES = 1'b0,
		REG_PROCESSES = 1'b1
	} reg_idx_t;

	// What a returning memory read is used for
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,
		OP_SUM,
		OP_CHECK,
		OP_ADD
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SUM,
		ST_SCAN,
		ST_CHECK,
		ST_DECIDE,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [RES_W-1:0] col;
	} rtn_t;

	typedef struct packed {
		logic [PROC_W-1:0] proc_id;
		logic              deadlocked;
		logic              any;
		logic              last;
	} emit_t;

	function automatic logic [MAT_AW-1:0] mat_addr(input logic [PROC_W-1:0] p,
			input logic [RES_W-1:0] r);
		mat_addr = MAT_AW'(int'(p) * MAX_RESOURCES + int'(r));
	endfunction

	// Register value to last index in use: zero counts as one, saturate at the maximum
	function automatic logic [PROC_W-1:0] proc_last(input logic [CFG_PROC_W-1:0] v);
		if (v == '0) return '0;
		else if (int'(v) > MAX_PROCESSES) return PROC_W'(MAX_PROCESSES - 1);
		else return PROC_W'(int'(v) - 1);
	endfunction

	function automatic logic [RES_W-1:0] res_last(input logic [CFG_RES_W-1:0] v);
		if (v == '0) return '0;
		else if (int'(v) > MAX_RESOURCES) return RES_W'(MAX_RESOURCES - 1);
		else return RES_W'(int'(v) - 1);
	endfunction

endpackage

### hdl/mdd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module mdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/mdd_avail.sv
// Available-instance file and request compare of the deadlock detector.
// Uses mdd_pkg; consumes the read data of the total, holding and request RAMs.
module mdd_avail (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mdd_pkg::rtn_t              rtn_s1,
	input  logic [mdd_pkg::AMT_W-1:0]  total_rdata,
	input  logic [mdd_pkg::AMT_W-1:0]  hold_rdata,
	input  logic [mdd_pkg::AMT_W-1:0]  req_rdata,
	output logic                       fail
);

	logic signed [mdd_pkg::AVAIL_W-1:0] avail_q [mdd_pkg::MAX_RESOURCES];
	logic signed [mdd_pkg::AVAIL_W-1:0] cur;
	logic signed [mdd_pkg::AVAIL_W-1:0] total_ext;
	logic signed [mdd_pkg::AVAIL_W-1:0] hold_ext;
	logic signed [mdd_pkg::AVAIL_W-1:0] req_ext;

	assign cur       = avail_q[rtn_s1.col];
	assign total_ext = $signed(mdd_pkg::AVAIL_W'(total_rdata));
	assign hold_ext  = $signed(mdd_pkg::AVAIL_W'(hold_rdata));
	assign req_ext   = $signed(mdd_pkg::AVAIL_W'(req_rdata));

	// A request that exceeds what is left blocks the process
	assign fail = (rtn_s1.op == mdd_pkg::OP_CHECK) && (req_ext > cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < mdd_pkg::MAX_RESOURCES; r++) begin
				avail_q[r] <= '0;
			end
		end else begin
			case (rtn_s1.op)
				mdd_pkg::OP_INIT: avail_q[rtn_s1.col] <= total_ext;
				mdd_pkg::OP_SUM:  avail_q[rtn_s1.col] <= cur - hold_ext;
				mdd_pkg::OP_ADD:  avail_q[rtn_s1.col] <= cur + hold_ext;
				default: ;
			endcase
		end
	end

endmodule

### hdl/mdd_ctrl.sv
// Run sequencer of the deadlock detector: counters, read issue, finished flags, result walk.
// Uses mdd_pkg; drives the RAM read addresses and tags each read for mdd_avail.
module mdd_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mdd_pkg::PROC_W-1:0]  np_last,
	input  logic [mdd_pkg::RES_W-1:0]   nr_last,
	input  logic                        fail,
	input  logic                        emit_take,
	output logic                        idle,
	output logic [mdd_pkg::MAT_AW-1:0]  mat_raddr,
	output logic [mdd_pkg::RES_W-1:0]   col,
	output mdd_pkg::rtn_t               rtn_s1,
	output logic                        emit_valid,
	output mdd_pkg::emit_t              emit
);

	mdd_pkg::state_t state_q, state_d;
	logic [mdd_pkg::PROC_W-1:0]        i_q, i_d, k_q, k_d, np_last_q, np_last_d;
	logic [mdd_pkg::RES_W-1:0]         j_q, j_d, nr_last_q, nr_last_d;
	logic [mdd_pkg::MAX_PROCESSES-1:0] fin_q, fin_d, in_use;
	logic                              fits_q, fits_d;
	mdd_pkg::op_t                      issue_op;
	logic                              i_end, j_end, k_end;

	assign i_end = (i_q == np_last_q);
	assign j_end = (j_q == nr_last_q);
	assign k_end = (k_q == np_last_q);

	assign mat_raddr = mdd_pkg::mat_addr(i_q, j_q);
	assign col       = j_q;
	assign idle      = (state_q == mdd_pkg::ST_IDLE);

	always_comb begin
		for (int p = 0; p < mdd_pkg::MAX_PROCESSES; p++) begin
			in_use[p] = (p <= int'(np_last_q));
		end
	end

	assign emit_valid      = (state_q == mdd_pkg::ST_EMIT);
	assign emit.proc_id    = i_q;
	assign emit.deadlocked = ~fin_q[i_q];
	assign emit.any        = |(~fin_q & in_use);
	assign emit.last       = i_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mdd_pkg::ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			fin_q     <= '0;
			fits_q    <= 1'b0;
			np_last_q <= '0;
			nr_last_q <= '0;
			rtn_s1    <= '{op: mdd_pkg::OP_NONE, col: '0};
		end else begin
			state_q   <= state_d;
			i_q       <= i_d;
			j_q       <= j_d;
			k_q       <= k_d;
			fin_q     <= fin_d;
			fits_q    <= fits_d;
			np_last_q <= np_last_d;
			nr_last_q <= nr_last_d;
			rtn_s1    <= '{op: issue_op, col: j_q};
		end
	end

	always_comb begin
		logic advance;
		state_d   = state_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		fin_d     = fin_q;
		np_last_d = np_last_q;
		nr_last_d = nr_last_q;
		issue_op  = mdd_pkg::OP_NONE;
		advance   = 1'b0;
		// drop the fit as soon as one request does not fit
		fits_d    = fits_q & ~((rtn_s1.op == mdd_pkg::OP_CHECK) && fail);

		case (state_q)
			mdd_pkg::ST_IDLE: begin
				if (start) begin
					np_last_d = np_last;
					nr_last_d = nr_last;
					i_d       = '0;
					j_d       = '0;
					k_d       = '0;
					fin_d     = '0;
					state_d   = mdd_pkg::ST_INIT;
				end
			end
			mdd_pkg::ST_INIT: begin
				issue_op = mdd_pkg::OP_INIT;
				if (j_end) begin
					j_d     = '0;
					state_d = mdd_pkg::ST_SUM;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			mdd_pkg::ST_SUM: begin
				issue_op = mdd_pkg::OP_SUM;
				if (j_end) begin
					j_d = '0;
					if (i_end) begin
						i_d     = '0;
						state_d = mdd_pkg::ST_SCAN;
					end else begin
						i_d = i_q + 1'b1;
					end
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			mdd_pkg::ST_SCAN: begin
				if (fin_q[i_q]) begin
					advance = 1'b1;
				end else begin
					fits_d  = 1'b1;
					j_d     = '0;
					state_d = mdd_pkg::ST_CHECK;
				end
			end
			mdd_pkg::ST_CHECK: begin
				issue_op = mdd_pkg::OP_CHECK;
				if (j_end) begin
					state_d = mdd_pkg::ST_DECIDE;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			mdd_pkg::ST_DECIDE: begin
				if (fits_d) begin
					fin_d[i_q] = 1'b1;
					j_d        = '0;
					state_d    = mdd_pkg::ST_ADD;
				end else begin
					advance = 1'b1;
				end
			end
			mdd_pkg::ST_ADD: begin
				issue_op = mdd_pkg::OP_ADD;
				if (j_end) begin
					advance = 1'b1;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			mdd_pkg::ST_EMIT: begin
				if (emit_take) begin
					if (i_end) begin
						i_d     = '0;
						state_d = mdd_pkg::ST_IDLE;
					end else begin
						i_d = i_q + 1'b1;
					end
				end
			end
			default: state_d = mdd_pkg::ST_IDLE;
		endcase

		// next process of the pass; after the last pass walk the results
		if (advance) begin
			if (i_end) begin
				i_d = '0;
				if (k_end) begin
					state_d = mdd_pkg::ST_EMIT;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = mdd_pkg::ST_SCAN;
				end
			end else begin
				i_d     = i_q + 1'b1;
				state_d = mdd_pkg::ST_SCAN;
			end
		end
	end

endmodule

### hdl/multi_instance_deadlock_detect_top.sv
// Top level of the multi-instance deadlock detector: APB registers, matrix RAMs, result register.
// Uses mdd_pkg, mdd_ram, mdd_ctrl and mdd_avail.

// Multi-instance deadlock detector. Load beats (command 0, 1, 2) write one total
// count, one holding entry or one request entry into on-chip RAMs; loads with an
// index past the matrix size are dropped. A run beat (command 3) computes
// available = total - column sum of holdings (signed), then makes
// processes_in_use passes over the processes, completing each unfinished process
// whose requests all fit and returning its holdings. It then emits one result
// beat per process in use, in order, with deadlocked, any_deadlock and a last
// marker on the final beat. Every matrix entry a run touches must have been
// loaded first. A run reads the totals and the holdings for the set-up, then
// scans the processes in each pass, reading the requests of each process it
// checks and, if it completes, its holdings, then walks the result beats; the
// single read port of each matrix RAM reads one entry per cycle. The input
// stalls for the whole run; the result register lets the last beat wait while
// the next item is taken. Configuration registers: resources_in_use at byte
// address 0, processes_in_use at 4; zero counts as one and values above the
// maximum saturate.
module multi_instance_deadlock_detect_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mdd_pkg::PADDR_W-1:0]    paddr,
	input  logic [mdd_pkg::PDATA_W-1:0]    pwdata,
	output logic [mdd_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// input beats
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mdd_pkg::CMD_W-1:0]      command,
	input  logic [mdd_pkg::PIDX_W-1:0]     process_index,
	input  logic [mdd_pkg::RIDX_W-1:0]     resource_index,
	input  logic [mdd_pkg::AMT_W-1:0]      amount,
	// result beats
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mdd_pkg::PIDX_W-1:0]     proc_id,
	output logic                           deadlocked,
	output logic                           any_deadlock,
	output logic                           last
);

	// Configuration registers
	logic [mdd_pkg::CFG_RES_W-1:0]  res_q;
	logic [mdd_pkg::CFG_PROC_W-1:0] proc_q;
	mdd_pkg::reg_idx_t              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = mdd_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= mdd_pkg::CFG_RES_W'(mdd_pkg::MAX_RESOURCES);
			proc_q <= mdd_pkg::CFG_PROC_W'(mdd_pkg::MAX_PROCESSES);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				mdd_pkg::REG_RESOURCES: res_q  <= pwdata[mdd_pkg::CFG_RES_W-1:0];
				mdd_pkg::REG_PROCESSES: proc_q <= pwdata[mdd_pkg::CFG_PROC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mdd_pkg::REG_RESOURCES: prdata = mdd_pkg::PDATA_W'(res_q);
			mdd_pkg::REG_PROCESSES: prdata = mdd_pkg::PDATA_W'(proc_q);
			default:                prdata = '0;
		endcase
	end

	// Input acceptance and load decode
	logic           ctrl_idle, in_acc, p_ok, r_ok;
	logic           we_total, we_hold, we_req, start;
	mdd_pkg::cmd_t  cmd;
	logic [mdd_pkg::MAT_AW-1:0] mat_waddr;

	assign in_stall = ~ctrl_idle;
	assign in_acc   = in_valid && !in_stall;
	assign cmd      = mdd_pkg::cmd_t'(command);
	assign p_ok     = int'(process_index) < mdd_pkg::MAX_PROCESSES;
	assign r_ok     = int'(resource_index) < mdd_pkg::MAX_RESOURCES;

	assign we_total  = in_acc && (cmd == mdd_pkg::CMD_LOAD_TOTAL) && r_ok;
	assign we_hold   = in_acc && (cmd == mdd_pkg::CMD_LOAD_HOLD) && p_ok && r_ok;
	assign we_req    = in_acc && (cmd == mdd_pkg::CMD_LOAD_REQ) && p_ok && r_ok;
	assign start     = in_acc && (cmd == mdd_pkg::CMD_RUN);
	assign mat_waddr = mdd_pkg::mat_addr(mdd_pkg::PROC_W'(process_index),
			mdd_pkg::RES_W'(resource_index));

	// Matrix and total RAMs
	logic [mdd_pkg::MAT_AW-1:0] mat_raddr;
	logic [mdd_pkg::RES_W-1:0]  col;
	logic [mdd_pkg::AMT_W-1:0]  total_rdata, hold_rdata, req_rdata;

	mdd_ram #(.WIDTH(mdd_pkg::AMT_W), .DEPTH(mdd_pkg::MAX_RESOURCES)) u_total_ram (
		.clk   (clk),
		.we    (we_total),
		.waddr (mdd_pkg::RES_W'(resource_index)),
		.wdata (amount),
		.raddr (col),
		.rdata (total_rdata)
	);

	mdd_ram #(.WIDTH(mdd_pkg::AMT_W), .DEPTH(mdd_pkg::MAT_DEPTH)) u_hold_ram (
		.clk   (clk),
		.we    (we_hold),
		.waddr (mat_waddr),
		.wdata (amount),
		.raddr (mat_raddr),
		.rdata (hold_rdata)
	);

	mdd_ram #(.WIDTH(mdd_pkg::AMT_W), .DEPTH(mdd_pkg::MAT_DEPTH)) u_req_ram (
		.clk   (clk),
		.we    (we_req),
		.waddr (mat_waddr),
		.wdata (amount),
		.raddr (mat_raddr),
		.rdata (req_rdata)
	);

	// Sequencer and available-count file
	mdd_pkg::rtn_t  rtn_s1;
	mdd_pkg::emit_t emit;
	logic           fail, emit_valid, emit_take;

	mdd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.np_last    (mdd_pkg::proc_last(proc_q)),
		.nr_last    (mdd_pkg::res_last(res_q)),
		.fail       (fail),
		.emit_take  (emit_take),
		.idle       (ctrl_idle),
		.mat_raddr  (mat_raddr),
		.col        (col),
		.rtn_s1     (rtn_s1),
		.emit_valid (emit_valid),
		.emit       (emit)
	);

	mdd_avail u_avail (
		.clk         (clk),
		.arst_n      (arst_n),
		.rtn_s1      (rtn_s1),
		.total_rdata (total_rdata),
		.hold_rdata  (hold_rdata),
		.req_rdata   (req_rdata),
		.fail        (fail)
	);

	// Result register: load a new beat when empty or when the held beat leaves
	logic           out_valid_q;
	mdd_pkg::emit_t out_q;

	assign emit_take = emit_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_take) begin
			out_q <= emit;
		end
	end

	assign out_valid    = out_valid_q;
	assign proc_id      = out_q.proc_id;
	assign deadlocked   = out_q.deadlocked;
	assign any_deadlock = out_q.any;
	assign last         = out_q.last;

endmodule

### tb/mdd_checker.sv
// Checker for the multi-instance deadlock detector: tracks the APB register writes and the
// input beats, predicts every result beat and compares it with what the block emits.
// Depends on mdd_pkg for the command, register and result types.
`timescale 1ns / 1ps

module mdd_checker
	import mdd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [CMD_W-1:0]      command,
	input  logic [PIDX_W-1:0]     process_index,
	input  logic [RIDX_W-1:0]     resource_index,
	input  logic [AMT_W-1:0]      amount,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [PIDX_W-1:0]     proc_id,
	input  logic                  deadlocked,
	input  logic                  any_deadlock,
	input  logic                  last,
	output int                    fail_count,
	output int                    pending
);

	localparam int REPORT_LIMIT = 10;

	logic [AMT_W-1:0]      total_mem [MAX_RESOURCES];
	logic [AMT_W-1:0]      hold_mem  [MAX_PROCESSES][MAX_RESOURCES];
	logic [AMT_W-1:0]      req_mem   [MAX_PROCESSES][MAX_RESOURCES];
	logic [CFG_RES_W-1:0]  res_cfg;
	logic [CFG_PROC_W-1:0] proc_cfg;
	emit_t                 verdict_q [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// zero counts as one, anything above the maximum saturates
	function automatic int in_use_count(input int v, input int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic logic signed [AVAIL_W-1:0] widen(input logic [AMT_W-1:0] v);
		return $signed({{(AVAIL_W-AMT_W){1'b0}}, v});
	endfunction

	task automatic predict_run();
		int                        nr;
		int                        np;
		logic signed [AVAIL_W-1:0] avail [MAX_RESOURCES];
		logic [AVAIL_W-1:0]        col_sum;
		logic                      done [MAX_PROCESSES];
		logic                      fits;
		logic                      stuck;
		emit_t                     e;
		nr = in_use_count(int'(res_cfg), MAX_RESOURCES);
		np = in_use_count(int'(proc_cfg), MAX_PROCESSES);
		for (int j = 0; j < nr; j++) begin
			col_sum = '0;
			for (int i = 0; i < np; i++)
				col_sum += hold_mem[i][j];
			avail[j] = widen(total_mem[j]) - $signed(col_sum);
		end
		for (int i = 0; i < MAX_PROCESSES; i++)
			done[i] = 1'b0;
		for (int k = 0; k < np; k++) begin
			for (int i = 0; i < np; i++) begin
				if (!done[i]) begin
					fits = 1'b1;
					for (int j = 0; j < nr; j++)
						if (widen(req_mem[i][j]) > avail[j])
							fits = 1'b0;
					if (fits) begin
						done[i] = 1'b1;
						for (int j = 0; j < nr; j++)
							avail[j] += widen(hold_mem[i][j]);
					end
				end
			end
		end
		stuck = 1'b0;
		for (int i = 0; i < np; i++)
			if (!done[i])
				stuck = 1'b1;
		for (int i = 0; i < np; i++) begin
			e.proc_id    = PROC_W'(i);
			e.deadlocked = !done[i];
			e.any        = stuck;
			e.last       = (i == np - 1);
			verdict_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		emit_t exp_beat;
		emit_t got_beat;
		if (!arst_n) begin
			res_cfg  = CFG_RES_W'(MAX_RESOURCES);
			proc_cfg = CFG_PROC_W'(MAX_PROCESSES);
			verdict_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1]))
					REG_RESOURCES: res_cfg  = pwdata[CFG_RES_W-1:0];
					REG_PROCESSES: proc_cfg = pwdata[CFG_PROC_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (cmd_t'(command))
					CMD_LOAD_TOTAL:
						if (int'(resource_index) < MAX_RESOURCES)
							total_mem[resource_index] = amount;
					CMD_LOAD_HOLD:
						if (int'(process_index) < MAX_PROCESSES &&
								int'(resource_index) < MAX_RESOURCES)
							hold_mem[process_index][resource_index] = amount;
					CMD_LOAD_REQ:
						if (int'(process_index) < MAX_PROCESSES &&
								int'(resource_index) < MAX_RESOURCES)
							req_mem[process_index][resource_index] = amount;
					CMD_RUN: predict_run();
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got_beat.proc_id    = proc_id;
				got_beat.deadlocked = deadlocked;
				got_beat.any        = any_deadlock;
				got_beat.last       = last;
				if (verdict_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result beat with nothing expected: proc_id %0d deadlocked %0b any %0b last %0b",
							$realtime, got_beat.proc_id, got_beat.deadlocked, got_beat.any,
							got_beat.last);
				end else begin
					exp_beat = verdict_q.pop_front();
					if (got_beat.proc_id !== exp_beat.proc_id ||
							got_beat.deadlocked !== exp_beat.deadlocked ||
							got_beat.any !== exp_beat.any ||
							got_beat.last !== exp_beat.last) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: result mismatch: proc_id %0d/%0d deadlocked %0b/%0b any %0b/%0b last %0b/%0b (expected/actual)",
								$realtime, exp_beat.proc_id, got_beat.proc_id,
								exp_beat.deadlocked, got_beat.deadlocked,
								exp_beat.any, got_beat.any, exp_beat.last, got_beat.last);
					end
				end
			end
			pending <= verdict_q.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the deadlock detector testbench: clock, reset, APB register writes, input beats
// and result back-pressure. Depends on mdd_pkg, mdd_checker and the block's top level.
`timescale 1ns / 1ps

module tb;
	import mdd_pkg::*;

	localparam int CYCLE_LIMIT   = 800000;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 600;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    command;
	logic [PIDX_W-1:0]   process_index;
	logic [RIDX_W-1:0]   resource_index;
	logic [AMT_W-1:0]    amount;
	logic                out_valid;
	logic                out_stall;
	logic [PIDX_W-1:0]   proc_id;
	logic                deadlocked;
	logic                any_deadlock;
	logic                last;

	int fail_count;
	int pending;

	// idle percentages for sender and receiver, changed between phases
	int tx_pct = 0;
	int rx_pct = 0;
	// long receiver hold-off: bump hold_request to start one
	int hold_request = 0;
	int hold_served = 0;
	int hold_left = 0;

	// in-use sizes after the last register writes
	int cur_nr = MAX_RESOURCES;
	int cur_np = MAX_PROCESSES;

	// which store entries hold a loaded value; a run must never read any other
	bit tot_set  [MAX_RESOURCES];
	bit hold_set [MAX_PROCESSES][MAX_RESOURCES];
	bit req_set  [MAX_PROCESSES][MAX_RESOURCES];

	multi_instance_deadlock_detect_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.process_index  (process_index),
		.resource_index (resource_index),
		.amount         (amount),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.proc_id        (proc_id),
		.deadlocked     (deadlocked),
		.any_deadlock   (any_deadlock),
		.last           (last)
	);

	mdd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.process_index  (process_index),
		.resource_index (resource_index),
		.amount         (amount),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.proc_id        (proc_id),
		.deadlocked     (deadlocked),
		.any_deadlock   (any_deadlock),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: random stall at rx_pct, or a solid hold-off of HOLD_CYCLES once
	// requested. One assignment per edge keeps out_stall free of ordering races.
	always @(posedge clk) begin
		if (hold_served != hold_request) begin
			hold_served = hold_request;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (rx_pct > 0) && ($urandom_range(0, 99) < rx_pct);
		end
	end

	// Watchdog: drop the run if it never drains.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	function automatic int in_use_count(input int v, input int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Amounts lean small so that runs mix completions and deadlocks; the extremes
	// and the full range still show up now and then.
	function automatic logic [AMT_W-1:0] pick_amount(input cmd_t c);
		int x;
		x = $urandom_range(0, 99);
		if (x < 4) return '0;
		if (x < 8) return '1;
		if (x < 14) return AMT_W'($urandom);
		case (c)
			CMD_LOAD_TOTAL: return AMT_W'($urandom_range(4, 60));
			CMD_LOAD_HOLD:  return AMT_W'($urandom_range(0, 3));
			default:        return AMT_W'($urandom_range(0, 6));
		endcase
	endfunction

	// APB write: setup, access, then psel low again so that back-to-back
	// writes never touch psel twice in one step.
	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one beat and hold it until the block takes it. An idle gap, if any,
	// comes first, so valid stays high from one beat to the next when there is none.
	task automatic send_beat(input cmd_t c, input logic [PIDX_W-1:0] p,
			input logic [RIDX_W-1:0] r, input logic [AMT_W-1:0] a);
		if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_pct);
		end
		in_valid       <= 1'b1;
		command        <= c;
		process_index  <= p;
		resource_index <= r;
		amount         <= a;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load_entry(input cmd_t c, input logic [PIDX_W-1:0] p,
			input logic [RIDX_W-1:0] r, input logic [AMT_W-1:0] a);
		case (c)
			CMD_LOAD_TOTAL: tot_set[r] = 1'b1;
			CMD_LOAD_HOLD:  hold_set[p][r] = 1'b1;
			CMD_LOAD_REQ:   req_set[p][r] = 1'b1;
			default: ;
		endcase
		send_beat(c, p, r, a);
	endtask

	// Load every entry the next run reads that was never loaded, then start the run.
	// The run beat carries random fields, which the block ignores.
	task automatic run_detect();
		for (int j = 0; j < cur_nr; j++)
			if (!tot_set[j])
				load_entry(CMD_LOAD_TOTAL, PIDX_W'($urandom), RIDX_W'(j),
					pick_amount(CMD_LOAD_TOTAL));
		for (int i = 0; i < cur_np; i++)
			for (int j = 0; j < cur_nr; j++) begin
				if (!hold_set[i][j])
					load_entry(CMD_LOAD_HOLD, PIDX_W'(i), RIDX_W'(j),
						pick_amount(CMD_LOAD_HOLD));
				if (!req_set[i][j])
					load_entry(CMD_LOAD_REQ, PIDX_W'(i), RIDX_W'(j),
						pick_amount(CMD_LOAD_REQ));
			end
		send_beat(CMD_RUN, PIDX_W'($urandom), RIDX_W'($urandom), AMT_W'($urandom));
	endtask

	// Drop valid, wait for every predicted result, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int res_val, input int proc_val);
		wait_idle();
		write_reg(REG_RESOURCES, PDATA_W'(res_val));
		write_reg(REG_PROCESSES, PDATA_W'(proc_val));
		cur_nr = in_use_count(res_val, MAX_RESOURCES);
		cur_np = in_use_count(proc_val, MAX_PROCESSES);
	endtask

	// Mostly loads into the entries in use followed by runs; the rest is noise
	// loads anywhere in the stores and back-to-back runs on unchanged stores.
	task automatic random_phase(input int n_ops);
		int   pick;
		cmd_t c;
		for (int k = 0; k < n_ops; k++) begin
			pick = $urandom_range(0, 99);
			c = cmd_t'($urandom_range(CMD_LOAD_TOTAL, CMD_LOAD_REQ));
			if (pick < 14) begin
				run_detect();
			end else if (pick < 72) begin
				load_entry(c, PIDX_W'($urandom_range(0, cur_np - 1)),
					RIDX_W'($urandom_range(0, cur_nr - 1)), pick_amount(c));
			end else if (pick < 90) begin
				load_entry(c, PIDX_W'($urandom), RIDX_W'($urandom), AMT_W'($urandom));
			end else begin
				run_detect();
				run_detect();
			end
		end
		run_detect();
	endtask

	initial begin
		// every input known from time zero, with reset asserted first
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		command        = CMD_LOAD_TOTAL;
		process_index  = '0;
		resource_index = '0;
		amount         = '0;
		out_stall      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: one process, one resource.
		set_config(1, 1);
		// process index means nothing to a total load
		load_entry(CMD_LOAD_TOTAL, 4'hF, 3'd0, 8'h00);
		load_entry(CMD_LOAD_HOLD, 4'h0, 3'd0, 8'h00);
		load_entry(CMD_LOAD_REQ, 4'h0, 3'd0, 8'h00);
		run_detect();
		// request above available: deadlocked
		load_entry(CMD_LOAD_REQ, 4'h0, 3'd0, 8'hFF);
		run_detect();
		// request equal to available: completes
		load_entry(CMD_LOAD_TOTAL, 4'h0, 3'd0, 8'hFF);
		run_detect();
		// holdings above total: available goes negative, even a zero request fails
		load_entry(CMD_LOAD_HOLD, 4'h0, 3'd0, 8'hFF);
		load_entry(CMD_LOAD_TOTAL, 4'h0, 3'd0, 8'h00);
		load_entry(CMD_LOAD_REQ, 4'h0, 3'd0, 8'h00);
		run_detect();
		// entries outside the processes and resources in use must not matter
		load_entry(CMD_LOAD_HOLD, 4'hF, 3'd7, 8'hFF);
		load_entry(CMD_LOAD_REQ, 4'hF, 3'd7, 8'hFF);
		load_entry(CMD_LOAD_TOTAL, 4'h5, 3'd7, 8'hFF);
		run_detect();
		// a run leaves the request store alone: same answer again
		run_detect();

		// Zero in both registers counts as one.
		set_config(0, 0);
		run_detect();
		load_entry(CMD_LOAD_TOTAL, 4'hA, 3'd0, 8'hAA);
		load_entry(CMD_LOAD_HOLD, 4'h0, 3'd0, 8'h55);
		load_entry(CMD_LOAD_REQ, 4'h0, 3'd0, 8'h55);
		run_detect();

		// Random phases. The first two push one register past its maximum while the
		// other stays at one, so the full width and the full depth are both read.
		tx_pct = 0;  rx_pct = 0;
		set_config(15, 1);
		random_phase(4);

		tx_pct = 84; rx_pct = 0;
		set_config(1, 31);
		random_phase(4);

		tx_pct = 0;  rx_pct = 84;
		set_config(3, 4);
		random_phase(8);

		tx_pct = 15; rx_pct = 15;
		set_config(2, 6);
		random_phase(8);

		// Long result hold-off while runs keep coming: the block fills and stalls
		// its input. Then pause the sender until everything has drained.
		tx_pct = 0;  rx_pct = 0;
		set_config(3, 5);
		hold_request++;
		repeat (4) run_detect();
		wait_idle();
		random_phase(6);

		tx_pct = 0;  rx_pct = 0;
		set_config(4, 7);
		random_phase(6);

		// drain, settle, verdict
		wait_idle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
